@@ rtl/ffha_pkg.sv @@
// Shared constants, codes and structs for the first-fit heap allocator.
// No dependencies; the engine, the top level and the testbench import this package.
`default_nettype none

package ffha_pkg;

  localparam int unsigned ARENA_PAGES  = 16;
  localparam int unsigned PAGE_BYTES   = 4096;
  localparam int unsigned ARENA_BYTES  = ARENA_PAGES * PAGE_BYTES;
  localparam int unsigned ARENA_WORDS  = ARENA_BYTES / 8;
  localparam int unsigned WORD_AW      = $clog2(ARENA_WORDS);
  localparam int unsigned OFF_W        = $clog2(ARENA_BYTES) + 1;
  localparam int unsigned HDR_BYTES    = 16;
  localparam int unsigned SPLIT_MIN    = 32;
  localparam int unsigned PAGE_WORDS   = PAGE_BYTES / 8;
  localparam int unsigned PAGE_AW      = $clog2(PAGE_WORDS);
  localparam int unsigned CHUNK_WORDS  = 32;
  localparam int unsigned CHUNK_AW     = $clog2(CHUNK_WORDS);
  localparam int unsigned CNT_W        = $clog2(CHUNK_WORDS + 1);
  localparam int unsigned HOP_LIMIT    = ARENA_BYTES / HDR_BYTES + 1;
  localparam int unsigned HOP_W        = $clog2(HOP_LIMIT + 1);

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_SIZE    = 2'd2,
    CMD_REALLOC = 2'd3
  } cmd_t;

  typedef struct packed {
    logic        init;
    logic [63:0] base;
    logic        arena_ok;
  } cfg_t;

  typedef struct packed {
    logic [63:0] value;
    logic        ok;
    logic        freed_valid;
    logic [63:0] freed_pointer;
    logic [63:0] freed_size;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/ffha_ram.sv @@
// Generic single-port synchronous RAM with a registered read.
// Standalone; used for the arena and for the copy buffer.
`default_nettype none

module ffha_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

@@ rtl/ffha_engine.sv @@
// Command sequencer of the allocator: owns the arena RAM, the copy buffer
// and the free-list head. Depends on ffha_pkg and ffha_ram.
`default_nettype none

module ffha_engine (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire ffha_pkg::cfg_t cfg,
  input  wire logic           in_valid,
  output logic                ready,
  input  wire logic [1:0]     command,
  input  wire logic [63:0]    pointer,
  input  wire logic [63:0]    request_size,
  input  wire logic           res_free,
  output logic                res_valid,
  output ffha_pkg::res_t      res
);
  import ffha_pkg::*;

  localparam logic [OFF_W-1:0] AB_N = OFF_W'(ARENA_BYTES);

  typedef struct packed {
    logic             ok;
    logic [OFF_W-1:0] off;
  } chk_t;

  typedef struct packed {
    logic             fail;
    logic [OFF_W-1:0] bytes;
  } need_t;

  typedef enum logic [1:0] {K_ALLOC, K_FREE, K_SIZE, K_REALLOC} kind_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_PREP, S_HDR, S_DATA, S_HEAD, S_APREP, S_AHOP, S_ARD1,
    S_ARD2, S_ACHK, S_SPL1, S_SPL2, S_SPL3, S_LINK, S_CINIT, S_CCHUNK, S_CRD,
    S_CWR, S_DONE
  } state_t;

  // Header placement check: inside the arena with room for a header, 8-aligned.
  function automatic chk_t hdr_check(logic [63:0] va, logic [63:0] base);
    logic [64:0] diff;
    chk_t        c;
    diff  = {1'b0, va} - {1'b0, base};
    c.off = diff[OFF_W-1:0];
    c.ok  = !diff[64] && (diff[63:OFF_W] == '0) &&
            (diff[OFF_W-1:0] <= AB_N - OFF_W'(HDR_BYTES)) && (va[2:0] == 3'd0);
    return c;
  endfunction

  function automatic logic size_fits(logic [63:0] sz, logic [OFF_W-1:0] off);
    logic [OFF_W-1:0] room;
    room = AB_N - off;
    return (sz[63:OFF_W] == '0) && (sz[OFF_W-1:0] >= OFF_W'(HDR_BYTES)) &&
           (sz[2:0] == 3'd0) && (sz[OFF_W-1:0] <= room);
  endfunction

  function automatic need_t need_bytes(logic [63:0] req);
    logic             big;
    logic [OFF_W-1:0] p;
    logic [OFF_W:0]   nd;
    need_t            n;
    big = (req[63:OFF_W] != '0) || (req[OFF_W-1:0] > AB_N);
    p   = (req[OFF_W-1:0] < OFF_W'(HDR_BYTES)) ? OFF_W'(HDR_BYTES) : req[OFF_W-1:0];
    nd  = (({1'b0, p} + (OFF_W+1)'(7)) & ~(OFF_W+1)'(7)) + (OFF_W+1)'(HDR_BYTES);
    n.fail  = big || (nd > {1'b0, AB_N});
    n.bytes = nd[OFF_W-1:0];
    return n;
  endfunction

  function automatic logic [WORD_AW-1:0] widx(logic [OFF_W-1:0] off);
    return off[WORD_AW+2:3];
  endfunction

  state_t               state;
  kind_t                kind;
  logic                 p_free;
  logic [WORD_AW-1:0]   clr_idx;
  logic [63:0]          ptr;
  logic [63:0]          req;
  logic [63:0]          hdr_va;
  logic [OFF_W-1:0]     hdr_off;
  logic [63:0]          bsz;
  logic [63:0]          bnext;
  logic [63:0]          cur;
  logic [OFF_W-1:0]     cur_off;
  logic [WORD_AW-1:0]   prev_w;
  logic                 first;
  logic [HOP_W-1:0]     hop;
  logic [OFF_W-1:0]     need;
  logic [OFF_W-1:0]     left;
  logic [63:0]          link;
  logic [63:0]          list_head;
  logic [OFF_W-1:0]     old;
  logic [63:0]          res_val;
  logic                 freed;
  logic [OFF_W-1:0]     fsize;
  logic [WORD_AW:0]     src_w;
  logic [WORD_AW:0]     dst_w;
  logic [WORD_AW:0]     len_w;
  logic [CNT_W-1:0]     n;
  logic [CNT_W-1:0]     ci;
  logic                 pend;
  logic [CHUNK_AW-1:0]  pidx;

  logic [63:0]          chk_va;
  chk_t                 chk;
  need_t                nd;
  logic                 a_we;
  logic [WORD_AW-1:0]   a_addr;
  logic [63:0]          a_wdata;
  logic [63:0]          a_q;
  logic                 b_we;
  logic [CHUNK_AW-1:0]  b_addr;
  logic [63:0]          b_q;
  logic [OFF_W-1:0]     split_off;
  logic [OFF_W-1:0]     fit_left;
  logic [WORD_AW:0]     src_rd;
  logic [WORD_AW:0]     dst_wr;
  logic [WORD_AW:0]     sr;
  logic [WORD_AW:0]     dr;
  logic [WORD_AW:0]     m0;
  logic [WORD_AW:0]     m1;
  logic [WORD_AW:0]     m2;

  ffha_ram #(.WIDTH(64), .DEPTH(ARENA_WORDS)) u_arena (
    .clk(clk), .we(a_we), .addr(a_addr), .wdata(a_wdata), .rdata(a_q)
  );

  ffha_ram #(.WIDTH(64), .DEPTH(CHUNK_WORDS)) u_buf (
    .clk(clk), .we(b_we), .addr(b_addr), .wdata(a_q), .rdata(b_q)
  );

  // One shared header checker; the state picks which address it looks at.
  always_comb begin
    unique case (state)
      S_HDR:   chk_va = hdr_va;
      S_HEAD:  chk_va = list_head;
      S_ACHK:  chk_va = bnext;
      default: chk_va = cur;
    endcase
  end

  assign chk       = hdr_check(chk_va, cfg.base);
  assign nd        = need_bytes(req);
  assign split_off = cur_off + need;
  assign fit_left  = bsz[OFF_W-1:0] - need;
  assign src_rd    = src_w + (WORD_AW+1)'(ci);
  assign dst_wr    = dst_w + (WORD_AW+1)'(pidx);

  // Chunk length: no page crossing on either side, at most one buffer.
  assign sr = (WORD_AW+1)'(PAGE_WORDS) - (WORD_AW+1)'(src_w[PAGE_AW-1:0]);
  assign dr = (WORD_AW+1)'(PAGE_WORDS) - (WORD_AW+1)'(dst_w[PAGE_AW-1:0]);
  assign m0 = (len_w < (WORD_AW+1)'(CHUNK_WORDS)) ? len_w : (WORD_AW+1)'(CHUNK_WORDS);
  assign m1 = (sr < m0) ? sr : m0;
  assign m2 = (dr < m1) ? dr : m1;

  always_comb begin
    a_we    = 1'b0;
    a_addr  = widx(cur_off);
    a_wdata = list_head;
    unique case (state)
      S_CLEAR: begin
        a_we    = 1'b1;
        a_addr  = clr_idx;
        a_wdata = (clr_idx == '0) ? 64'(ARENA_BYTES) : 64'd0;
      end
      S_HDR:  a_addr = widx(chk.off);
      S_HEAD: begin
        a_we   = (list_head == 64'd0) || chk.ok;
        a_addr = widx(hdr_off) + WORD_AW'(1);
      end
      S_AHOP: a_addr = widx(chk.off);
      S_ARD1: a_addr = widx(cur_off) + WORD_AW'(1);
      S_SPL1: begin
        a_we    = 1'b1;
        a_addr  = widx(split_off);
        a_wdata = 64'(left);
      end
      S_SPL2: begin
        a_we    = 1'b1;
        a_addr  = widx(split_off) + WORD_AW'(1);
        a_wdata = bnext;
      end
      S_SPL3: begin
        a_we    = 1'b1;
        a_wdata = 64'(need);
      end
      S_LINK: begin
        a_we    = !first;
        a_addr  = prev_w + WORD_AW'(1);
        a_wdata = link;
      end
      S_CRD:  a_addr = src_rd[WORD_AW-1:0];
      S_CWR: begin
        a_we    = pend;
        a_addr  = dst_wr[WORD_AW-1:0];
        a_wdata = b_q;
      end
      default: ;
    endcase
  end

  assign b_we   = (state == S_CRD) && pend;
  assign b_addr = (state == S_CWR) ? ci[CHUNK_AW-1:0] : pidx;

  assign ready     = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    res.value         = res_val;
    res.ok            = (kind == K_FREE) ? freed : (res_val != 64'd0);
    res.freed_valid   = freed;
    res.freed_pointer = freed ? ptr : 64'd0;
    res.freed_size    = freed ? 64'(fsize) : 64'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg.init) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + WORD_AW'(1);
          if (clr_idx == WORD_AW'(ARENA_WORDS - 1)) begin
            list_head <= cfg.base;
            state     <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            ptr     <= pointer;
            req     <= request_size;
            freed   <= 1'b0;
            fsize   <= '0;
            res_val <= 64'd0;
            p_free  <= 1'b0;
            unique case (cmd_t'(command))
              CMD_ALLOC: begin
                kind  <= K_ALLOC;
                state <= S_APREP;
              end
              CMD_FREE: begin
                kind   <= K_FREE;
                p_free <= 1'b1;
                state  <= S_PREP;
              end
              CMD_SIZE: begin
                kind  <= K_SIZE;
                state <= S_PREP;
              end
              CMD_REALLOC: begin
                priority if (pointer == 64'd0) begin
                  kind  <= K_ALLOC;
                  state <= S_APREP;
                end else if (request_size == 64'd0) begin
                  kind   <= K_FREE;
                  p_free <= 1'b1;
                  state  <= S_PREP;
                end else begin
                  kind  <= K_REALLOC;
                  state <= S_PREP;
                end
              end
            endcase
          end
        end
        S_PREP: begin
          hdr_va <= ptr - 64'(HDR_BYTES);
          if (ptr[63:4] == '0 || ptr[2:0] != 3'd0 || !cfg.arena_ok) begin
            state <= S_DONE;
          end else begin
            state <= S_HDR;
          end
        end
        S_HDR: begin
          hdr_off <= chk.off;
          state   <= chk.ok ? S_DATA : S_DONE;
        end
        S_DATA: begin
          bsz <= a_q;
          old <= a_q[OFF_W-1:0] - OFF_W'(HDR_BYTES);
          priority if (!size_fits(a_q, hdr_off)) begin
            state <= S_DONE;
          end else if (p_free) begin
            state <= S_HEAD;
          end else if (kind == K_SIZE) begin
            res_val <= 64'(a_q[OFF_W-1:0] - OFF_W'(HDR_BYTES));
            state   <= S_DONE;
          end else if (a_q[OFF_W-1:0] == OFF_W'(HDR_BYTES)) begin
            state <= S_DONE;
          end else if (req[63:OFF_W] == '0 &&
                       req[OFF_W-1:0] <= a_q[OFF_W-1:0] - OFF_W'(HDR_BYTES)) begin
            res_val <= ptr;
            state   <= S_DONE;
          end else begin
            state <= S_APREP;
          end
        end
        S_HEAD: begin
          if (list_head == 64'd0 || chk.ok) begin
            list_head <= hdr_va;
            freed     <= 1'b1;
            fsize     <= bsz[OFF_W-1:0] - OFF_W'(HDR_BYTES);
          end
          state <= S_DONE;
        end
        S_APREP: begin
          cur   <= list_head;
          first <= 1'b1;
          hop   <= '0;
          need  <= nd.bytes;
          if (list_head == 64'd0 || !cfg.arena_ok || nd.fail) begin
            state <= S_DONE;
          end else begin
            state <= S_AHOP;
          end
        end
        S_AHOP: begin
          cur_off <= chk.off;
          if (cur == 64'd0 || hop == HOP_W'(HOP_LIMIT) || !chk.ok) begin
            state <= S_DONE;
          end else begin
            state <= S_ARD1;
          end
        end
        S_ARD1: begin
          bsz   <= a_q;
          state <= S_ARD2;
        end
        S_ARD2: begin
          bnext <= a_q;
          state <= S_ACHK;
        end
        S_ACHK: begin
          priority if (!size_fits(bsz, cur_off) || !(bnext == 64'd0 || chk.ok)) begin
            state <= S_DONE;
          end else if (bsz[OFF_W-1:0] >= need) begin
            left  <= fit_left;
            link  <= bnext;
            state <= (fit_left >= OFF_W'(SPLIT_MIN)) ? S_SPL1 : S_LINK;
          end else begin
            prev_w <= widx(cur_off);
            first  <= 1'b0;
            cur    <= bnext;
            hop    <= hop + HOP_W'(1);
            state  <= S_AHOP;
          end
        end
        S_SPL1: begin
          link  <= cur + 64'(need);
          state <= S_SPL2;
        end
        S_SPL2: state <= S_SPL3;
        S_SPL3: state <= S_LINK;
        S_LINK: begin
          if (first) begin
            list_head <= link;
          end
          res_val <= cur + 64'(HDR_BYTES);
          state   <= (kind == K_REALLOC) ? S_CINIT : S_DONE;
        end
        S_CINIT: begin
          src_w <= {1'b0, widx(hdr_off)} + (WORD_AW+1)'(2);
          dst_w <= {1'b0, widx(cur_off)} + (WORD_AW+1)'(2);
          len_w <= (WORD_AW+1)'(old >> 3);
          state <= S_CCHUNK;
        end
        S_CCHUNK: begin
          n    <= m2[CNT_W-1:0];
          ci   <= '0;
          pend <= 1'b0;
          if (len_w == '0) begin
            p_free <= 1'b1;
            state  <= S_PREP;
          end else begin
            state <= S_CRD;
          end
        end
        S_CRD: begin
          pend <= (ci != n);
          pidx <= ci[CHUNK_AW-1:0];
          if (ci != n) begin
            ci <= ci + CNT_W'(1);
          end else if (!pend) begin
            ci    <= '0;
            state <= S_CWR;
          end
        end
        S_CWR: begin
          pend <= (ci != n);
          pidx <= ci[CHUNK_AW-1:0];
          if (ci != n) begin
            ci <= ci + CNT_W'(1);
          end else if (!pend) begin
            src_w <= src_w + (WORD_AW+1)'(n);
            dst_w <= dst_w + (WORD_AW+1)'(n);
            len_w <= len_w - (WORD_AW+1)'(n);
            state <= S_CCHUNK;
          end
        end
        S_DONE: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/first_fit_heap_allocator.sv @@
// First-fit heap allocator top level: configuration register, handshakes
// and the output register. Depends on ffha_pkg and ffha_engine.
`default_nettype none

// The allocator manages one arena of ARENA_PAGES pages whose blocks carry
// 16-byte in-band headers (size, next-free link), stored in a single-port
// synchronous RAM of ARENA_WORDS 64-bit words. Commands are alloc, free,
// query size and realloc; each input transfer yields exactly one result
// transfer. After reset and after every base write, a clearing pass that
// writes one word per cycle rebuilds the arena over all ARENA_WORDS words
// (8192 for 16 pages); in_stall stays high during the pass. The block
// works on one command at a time; its RAM port does one access per cycle.
// A query size reads the block header, a free reads it and links the
// block in at the list head, and an alloc reads the size and link of each
// free-list block it visits, then writes the new link and, if the chosen
// block is split, its split headers. A growing realloc adds the size
// check, the alloc, a chunked copy of the payload (chunks are at most 32
// words and never cross a page), and a free. A finished result waits in
// the output register while the next command is already accepted and run.
module first_fit_heap_allocator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [63:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  command,
  input  wire logic [63:0] pointer,
  input  wire logic [63:0] request_size,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      value,
  output logic             ok,
  output logic             freed_valid,
  output logic [63:0]      freed_pointer,
  output logic [63:0]      freed_size
);
  import ffha_pkg::*;

  logic [63:0] base;
  logic        arena_ok;
  logic [63:0] base_new;
  cfg_t        cfg;
  logic        eng_ready;
  logic        res_valid;
  logic        res_free;
  res_t        res;
  res_t        out_r;

  // The low page bits of the base are ignored. The arena is usable only for
  // a nonzero base whose arena does not wrap past the top of the addresses.
  assign base_new = cfg_wdata & ~64'(PAGE_BYTES - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      base     <= 64'd0;
      arena_ok <= 1'b0;
    end else if (cfg_we) begin
      base     <= base_new;
      arena_ok <= (base_new != 64'd0) && (~base_new >= 64'(ARENA_BYTES));
    end
  end

  assign cfg.init     = cfg_we;
  assign cfg.base     = base;
  assign cfg.arena_ok = arena_ok;

  ffha_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .ready        (eng_ready),
    .command      (command),
    .pointer      (pointer),
    .request_size (request_size),
    .res_free     (res_free),
    .res_valid    (res_valid),
    .res          (res)
  );

  assign in_stall = !eng_ready;

  // Output register: a result moves in when the slot is empty or its
  // current transfer completes at this edge.
  assign res_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_free) begin
      out_r <= res;
    end
  end

  assign value         = out_r.value;
  assign ok            = out_r.ok;
  assign freed_valid   = out_r.freed_valid;
  assign freed_pointer = out_r.freed_pointer;
  assign freed_size    = out_r.freed_size;

  // Returned pointers and payload sizes are always multiples of 8.
  a_ok_aligned: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ok) |-> (value[2:0] == 3'd0))
    else $error("successful result is not 8-byte aligned");

  // Nothing released means no released pointer or size is reported.
  a_no_free_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !freed_valid) |-> (freed_pointer == 64'd0 && freed_size == 64'd0))
    else $error("freed fields set without a release");

  // A release always comes with success and a valid user pointer.
  a_freed_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && freed_valid) |-> (ok && freed_pointer != 64'd0))
    else $error("release reported without success");

  // A base write starts the clearing pass, which holds off new commands.
  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> in_stall)
    else $error("command accepted right after a base write");

endmodule

`default_nettype wire

@@ bench/tb_first_fit_heap_allocator.sv @@
// Self-checking testbench for the first-fit heap allocator top level.
// Depends on ffha_pkg and the allocator RTL; it needs no other file.
`default_nettype none

module tb_first_fit_heap_allocator;
  import ffha_pkg::*;

  // One command as the sender offers it.
  typedef struct {
    cmd_t        cmd;
    logic [63:0] ptr;
    logic [63:0] size;
  } heap_op_t;

  localparam int unsigned HEAP_WORDS = ARENA_PAGES * PAGE_BYTES / 8;
  localparam logic [63:0] ARENA_SPAN = 64'(ARENA_PAGES) * 64'(PAGE_BYTES);
  localparam logic [63:0] HDR = 64'd16;
  localparam logic [63:0] ALL_ONES = ~64'd0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [63:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  command = '0;
  logic [63:0] pointer = '0;
  logic [63:0] request_size = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] value;
  logic        ok;
  logic        freed_valid;
  logic [63:0] freed_pointer;
  logic [63:0] freed_size;

  first_fit_heap_allocator i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .pointer       (pointer),
    .request_size  (request_size),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .value         (value),
    .ok            (ok),
    .freed_valid   (freed_valid),
    .freed_pointer (freed_pointer),
    .freed_size    (freed_size)
  );

  always #1 clk = ~clk;

  // Commands waiting to be offered, and the results predicted for them in
  // order. Prediction happens when a command is queued, since the block
  // handles commands strictly one after another.
  heap_op_t    pending_ops[$];
  res_t        expected_results[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  bit          calm = 1'b0;

  // Shadow copy of the heap: arena contents, base address and list head.
  logic [63:0] heap_mem [HEAP_WORDS];
  logic [63:0] arena_base;
  logic [63:0] heap_head;

  // Pointers the shadow heap currently holds as allocated, and ones that
  // have been released; the latter feed double frees and stale accesses.
  logic [63:0] live_ptrs[$];
  logic [63:0] stale_ptrs[$];

  function automatic logic [63:0] mem_read(logic [63:0] va);
    logic [63:0] idx;
    idx = (va - arena_base) >> 3;
    return (idx < HEAP_WORDS) ? heap_mem[idx] : 64'd0;
  endfunction

  function automatic void mem_write(logic [63:0] va, logic [63:0] data);
    logic [63:0] idx;
    idx = (va - arena_base) >> 3;
    if (idx < HEAP_WORDS) heap_mem[idx] = data;
  endfunction

  function automatic void heap_rebuild();
    foreach (heap_mem[i]) heap_mem[i] = '0;
    heap_mem[0] = ARENA_SPAN;
    heap_head = arena_base;
  endfunction

  // The arena is usable only for a nonzero base whose end does not wrap.
  function automatic bit arena_top(output logic [63:0] last);
    last = '0;
    if (arena_base == 0 || 64'(ARENA_PAGES) > (ALL_ONES - arena_base) / 64'(PAGE_BYTES))
      return 1'b0;
    last = arena_base + ARENA_SPAN;
    return last > arena_base;
  endfunction

  function automatic bit header_fits(logic [63:0] last, logic [63:0] va);
    return va >= arena_base && va <= last - HDR && va[2:0] == 3'd0;
  endfunction

  function automatic bit block_size_fits(logic [63:0] last, logic [63:0] hdr,
                                         logic [63:0] sz);
    return sz >= HDR && sz <= last - hdr && sz[2:0] == 3'd0;
  endfunction

  // First-fit search with split; returns the user pointer or zero.
  function automatic logic [63:0] heap_alloc(logic [63:0] req);
    logic [63:0] last, payload, needed, prev, cur, bsz, bnext, left, link;
    prev = '0;
    if (heap_head == 0) return '0;
    if (req == 0) req = 1;
    payload = (req < HDR) ? HDR : req;
    if (payload > ALL_ONES - 64'd7) return '0;
    payload = (payload + 64'd7) & ~64'd7;
    if (payload > ALL_ONES - HDR) return '0;
    needed = payload + HDR;
    if (!arena_top(last) || needed > ARENA_SPAN) return '0;
    cur = heap_head;
    for (int hop = 0; cur != 0 && hop < ARENA_SPAN / HDR + 1; hop++) begin
      // A corrupt header or link ends the walk without touching the heap.
      if (!header_fits(last, cur)) break;
      bsz = mem_read(cur);
      bnext = mem_read(cur + 8);
      if (!block_size_fits(last, cur, bsz)) break;
      if (bnext != 0 && !header_fits(last, bnext)) break;
      if (bsz >= needed) begin
        left = bsz - needed;
        link = bnext;
        if (left >= 64'd32) begin
          link = cur + needed;
          mem_write(link, left);
          mem_write(link + 8, bnext);
          mem_write(cur, needed);
        end
        if (prev == 0) heap_head = link;
        else mem_write(prev + 8, link);
        return cur + HDR;
      end
      prev = cur;
      cur = bnext;
    end
    return '0;
  endfunction

  function automatic bit heap_release(logic [63:0] ptr, output logic [63:0] fsize);
    logic [63:0] last, hdr, bsz;
    fsize = '0;
    if (ptr < HDR || ptr[2:0] != 3'd0 || !arena_top(last)) return 1'b0;
    hdr = ptr - HDR;
    if (!header_fits(last, hdr)) return 1'b0;
    if (heap_head != 0 && !header_fits(last, heap_head)) return 1'b0;
    bsz = mem_read(hdr);
    if (!block_size_fits(last, hdr, bsz)) return 1'b0;
    mem_write(hdr + 8, heap_head);
    heap_head = hdr;
    fsize = bsz - HDR;
    return 1'b1;
  endfunction

  function automatic logic [63:0] heap_payload(logic [63:0] ptr);
    logic [63:0] last, hdr, bsz;
    if (ptr < HDR || ptr[2:0] != 3'd0 || !arena_top(last)) return '0;
    hdr = ptr - HDR;
    if (!header_fits(last, hdr)) return '0;
    bsz = mem_read(hdr);
    if (!block_size_fits(last, hdr, bsz)) return '0;
    return bsz - HDR;
  endfunction

  // Forward copy in chunks of at most 32 words that never cross a page;
  // each chunk is read whole before any of it is written.
  function automatic void heap_move(logic [63:0] src, logic [63:0] dst,
                                    logic [63:0] len);
    logic [63:0] chunk_buf [32];
    logic [63:0] sr, dr, chunk, n;
    while (len != 0) begin
      sr = 64'(PAGE_BYTES) - (src & 64'(PAGE_BYTES - 1));
      dr = 64'(PAGE_BYTES) - (dst & 64'(PAGE_BYTES - 1));
      chunk = len;
      if (chunk > sr) chunk = sr;
      if (chunk > dr) chunk = dr;
      if (chunk > 64'd256) chunk = 64'd256;
      n = chunk >> 3;
      if (n == 0) break;
      for (int i = 0; i < n; i++) chunk_buf[i] = mem_read(src + 8 * i);
      for (int i = 0; i < n; i++) mem_write(dst + 8 * i, chunk_buf[i]);
      src += n << 3;
      dst += n << 3;
      len -= n << 3;
    end
  endfunction

  function automatic res_t heap_command(cmd_t cmd, logic [63:0] ptr, logic [63:0] req);
    res_t        r;
    logic [63:0] fsize, old, np;
    bit          freed;
    r = '0;
    freed = 1'b0;
    fsize = '0;
    case (cmd)
      CMD_ALLOC: r.value = heap_alloc(req);
      CMD_FREE: freed = heap_release(ptr, fsize);
      CMD_SIZE: r.value = heap_payload(ptr);
      default: begin
        if (ptr == 0) begin
          r.value = heap_alloc(req);
        end else if (req == 0) begin
          freed = heap_release(ptr, fsize);
        end else begin
          old = heap_payload(ptr);
          if (old != 0) begin
            if (req <= old) begin
              r.value = ptr;
            end else begin
              np = heap_alloc(req);
              if (np != 0) begin
                heap_move(ptr, np, old);
                freed = heap_release(ptr, fsize);
                r.value = np;
              end
            end
          end
        end
      end
    endcase
    r.ok = (r.value != 0) || freed;
    r.freed_valid = freed;
    r.freed_pointer = freed ? ptr : 64'd0;
    r.freed_size = freed ? fsize : 64'd0;
    return r;
  endfunction

  // Queue one command, predict its result and keep the pointer lists current.
  task automatic queue_op(cmd_t cmd, logic [63:0] ptr, logic [63:0] req);
    heap_op_t op;
    res_t     r;
    op.cmd = cmd;
    op.ptr = ptr;
    op.size = req;
    r = heap_command(cmd, ptr, req);
    if (r.freed_valid) begin
      foreach (live_ptrs[i]) begin
        if (live_ptrs[i] == r.freed_pointer) begin
          live_ptrs.delete(i);
          break;
        end
      end
      stale_ptrs.push_back(r.freed_pointer);
      if (stale_ptrs.size() > 64) void'(stale_ptrs.pop_front());
    end
    if ((cmd == CMD_ALLOC || cmd == CMD_REALLOC) && r.value != 0 && r.value != ptr)
      live_ptrs.push_back(r.value);
    pending_ops.push_back(op);
    expected_results.push_back(r);
  endtask

  task automatic wait_idle();
    while (pending_ops.size() != 0 || expected_results.size() != 0) @(posedge clk);
  endtask

  // The register is written only once the block has drained; the write
  // starts a clearing pass, during which the block stalls its input.
  task automatic write_base(logic [63:0] data);
    wait_idle();
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    arena_base = data & ~64'(PAGE_BYTES - 1);
    heap_rebuild();
    live_ptrs.delete();
    stale_ptrs.delete();
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 64'($urandom_range(0, 128));
    if (r < 90) return 64'($urandom_range(129, 2048));
    if (r < 96) return 64'($urandom_range(2049, 70000));
    return rand64();
  endfunction

  function automatic logic [63:0] pick_pointer();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75 && live_ptrs.size() != 0)
      return live_ptrs[$urandom_range(0, live_ptrs.size() - 1)];
    if (r < 77 && stale_ptrs.size() != 0)
      return stale_ptrs[$urandom_range(0, stale_ptrs.size() - 1)];
    if (r < 82) return '0;
    if (r < 92) return arena_base + 64'($urandom_range(0, 70000));
    return rand64();
  endfunction

  // Mostly well-formed traffic on live blocks, with some garbage mixed in.
  task automatic queue_random(int unsigned count);
    int unsigned r;
    logic [63:0] req;
    for (int unsigned n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        queue_op(CMD_ALLOC, rand64(), pick_size());
      end else if (r < 60) begin
        queue_op(CMD_FREE, pick_pointer(), rand64());
      end else if (r < 75) begin
        queue_op(CMD_SIZE, pick_pointer(), rand64());
      end else begin
        req = ($urandom_range(0, 99) < 15) ? 64'd0 : pick_size();
        queue_op(CMD_REALLOC, pick_pointer(), req);
      end
    end
  endtask

  // Directed checks of a freshly built, usable arena.
  task automatic queue_directed();
    logic [63:0] p_all, p_a, p_b;
    queue_op(CMD_ALLOC, '0, 64'd65520);
    p_all = expected_results[$].value;
    queue_op(CMD_ALLOC, '0, 64'd8);
    queue_op(CMD_SIZE, p_all, '0);
    queue_op(CMD_FREE, p_all, '0);
    queue_op(CMD_ALLOC, '0, '0);
    p_a = expected_results[$].value;
    queue_op(CMD_ALLOC, ALL_ONES, 64'd17);
    p_b = expected_results[$].value;
    queue_op(CMD_ALLOC, '0, ALL_ONES);
    queue_op(CMD_ALLOC, '0, ALL_ONES - 64'd9);
    queue_op(CMD_ALLOC, '0, 64'd65536);
    queue_op(CMD_REALLOC, p_a, 64'd300);
    p_a = expected_results[$].value;
    queue_op(CMD_REALLOC, p_a, 64'd40);
    queue_op(CMD_REALLOC, '0, 64'd24);
    queue_op(CMD_REALLOC, p_b, '0);
    queue_op(CMD_FREE, '0, '0);
    queue_op(CMD_FREE, p_a + 64'd4, '0);
    queue_op(CMD_FREE, 64'd8, '0);
    queue_op(CMD_SIZE, ALL_ONES, ALL_ONES);
    queue_op(CMD_SIZE, p_a + 64'd64, '0);
    // Freeing one block twice makes the list loop on itself, so a request
    // that fits nowhere runs into the hop limit.
    queue_op(CMD_FREE, p_a, '0);
    queue_op(CMD_FREE, p_a, '0);
    queue_op(CMD_ALLOC, '0, 64'd60000);
    queue_op(CMD_ALLOC, '0, 64'd16);
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // Sender: a new command is put out only when the port is free or the
  // previous one has just been transferred.
  int unsigned send_gap = 0;
  heap_op_t    next_op;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || !in_stall) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_ops.size() != 0) begin
        next_op = pending_ops.pop_front();
        in_valid <= 1'b1;
        command <= next_op.cmd;
        pointer <= next_op.ptr;
        request_size <= next_op.size;
        send_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off: once, after a couple of hundred results, the
  // receiver refuses results long enough for the block to back up.
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (results_seen == 200 && !hold_done) begin
      hold_left <= 3000;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: checks every result transfer against the oldest prediction
  // and picks its own stall for the next cycle.
  int unsigned stall_left = 0;
  res_t        want;
  int unsigned roll;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result transfer: value %h ok %b", value, ok);
        end else begin
          want = expected_results.pop_front();
          if (value !== want.value || ok !== want.ok ||
              freed_valid !== want.freed_valid ||
              freed_pointer !== want.freed_pointer || freed_size !== want.freed_size) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result %0d mismatch", results_seen);
              $display("  expected value %h ok %b freed %b ptr %h size %h",
                       want.value, want.ok, want.freed_valid,
                       want.freed_pointer, want.freed_size);
              $display("  actual   value %h ok %b freed %b ptr %h size %h",
                       value, ok, freed_valid, freed_pointer, freed_size);
            end
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        roll = calm ? 0 : $urandom_range(0, 99);
        if (roll < 75) begin
          out_stall <= (hold_left != 0);
        end else begin
          out_stall <= 1'b1;
          stall_left <= (roll < 97) ? $urandom_range(0, 2) : $urandom_range(20, 80);
        end
      end
    end
  end

  initial begin
    arena_base = '0;
    heap_rebuild();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // With a zero base every command must fail.
    queue_op(CMD_ALLOC, '0, 64'd32);
    queue_op(CMD_SIZE, 64'd16, '0);
    queue_op(CMD_FREE, 64'd16, '0);
    queue_op(CMD_REALLOC, '0, 64'd64);

    // Low address bits must be ignored.
    write_base(64'h0000_0000_1234_5abc);
    queue_directed();
    // Sender pause: nothing more is offered until all results are back.
    wait_idle();
    queue_random(400);

    // Highest page: the arena would wrap, so everything fails.
    write_base(64'hffff_ffff_ffff_f000);
    queue_op(CMD_ALLOC, '0, 64'd1);
    queue_op(CMD_FREE, 64'hffff_ffff_ffff_f010, '0);
    queue_op(CMD_SIZE, 64'hffff_ffff_ffff_f010, '0);
    queue_op(CMD_REALLOC, '0, 64'd1);

    // Highest base whose arena still fits below the top of the space.
    write_base(64'hffff_ffff_fffe_ffff);
    calm = 1'b1;
    queue_directed();
    queue_random(300);
    wait_idle();
    calm = 1'b0;

    write_base(64'h8000_0000_0000_0000);
    queue_random(300);
    write_base(64'h0000_0000_0000_1000);
    queue_random(300);

    wait_idle();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_first_fit_heap_allocator passed");
    end else begin
      $display("tb_first_fit_heap_allocator failed");
    end
    $finish;
  end

  // Worst case is every command walking the hop limit and copying a full
  // arena; the timeout leaves several times the time that would take.
  initial begin
    #500000000;
    $display("tb_first_fit_heap_allocator failed");
    $finish;
  end

endmodule

`default_nettype wire
